FILE: rtl/core/stmr_pkg.sv
// ----------------------------------------------------------------------------
// stmr_pkg
// shared request codes, pipeline stage records and the master color table
// ----------------------------------------------------------------------------
package stmr_pkg;

    // request codes
    localparam logic [2:0] REQ_RENDER  = 3'd0;
    localparam logic [2:0] REQ_TILE    = 3'd1;
    localparam logic [2:0] REQ_ATTR    = 3'd2;
    localparam logic [2:0] REQ_PATTERN = 3'd3;
    localparam logic [2:0] REQ_PALETTE = 3'd4;

    // one incoming request
    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] screen_x;
        logic [7:0] screen_y;
        logic       page;
        logic [4:0] col;
        logic [4:0] row;
        logic [7:0] tile_value;
        logic [7:0] pattern_tile;
        logic [3:0] pattern_byte;
        logic [1:0] palette_sel;
        logic [1:0] color_slot;
        logic [5:0] color_code;
    } req_t;

    // after tile map and attribute lookup
    typedef struct packed {
        logic       valid;
        req_t       req;
        logic [2:0] px;
        logic [2:0] py;
        logic [7:0] tidx;
        logic [1:0] attr;
    } stage1_t;

    // after pattern lookup
    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [1:0] palette_sel;
        logic [1:0] color_slot;
        logic [5:0] color_code;
        logic [1:0] px;
        logic [1:0] attr;
        logic       in_range;
        logic [7:0] pbyte;
    } stage2_t;

    // after palette lookup, render requests only
    typedef struct packed {
        logic       valid;
        logic [5:0] shown;
    } stage3_t;

    localparam logic [23:0] MASTER_RGB [64] = '{
        24'h626262, 24'h001FB2, 24'h2400C8, 24'h5200B2,
        24'h730076, 24'h800024, 24'h730B00, 24'h522800,
        24'h244400, 24'h538E53, 24'h005C00, 24'h005324,
        24'h7092B2, 24'h000000, 24'h000000, 24'h000000,
        24'hABABAB, 24'h0D57FF, 24'h4B30FF, 24'h8A13FF,
        24'hBC01D6, 24'hD21269, 24'hC72E00, 24'h9D5400,
        24'h607B00, 24'h209800, 24'h00A300, 24'h009942,
        24'h007DB4, 24'h000000, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'h53AEFF, 24'h9085FF, 24'hD365FF,
        24'hFF57FF, 24'hFF5DCF, 24'hFF7757, 24'hFA9E00,
        24'hBDC700, 24'h7AE700, 24'h43F611, 24'h26EF7E,
        24'h2CD5F6, 24'h515151, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'hB6E1FF, 24'hCED1FF, 24'hE9C3FF,
        24'hFFBCFF, 24'hFFBDF4, 24'hFFC6C3, 24'hFFD59A,
        24'hE9E681, 24'hCEF481, 24'hB6FB9A, 24'hA9FAC3,
        24'hA9F0F4, 24'hB8B8B8, 24'h000000, 24'h000000
    };

    function automatic logic [23:0] rgb_lookup(input logic [5:0] code);
        return MASTER_RGB[code];
    endfunction

endpackage

FILE: rtl/core/stmr_map_stage.sv
// ----------------------------------------------------------------------------
// stmr_map_stage
// world x from scroll, tile map and attribute stores, first pipeline register
// ----------------------------------------------------------------------------
module stmr_map_stage #(
    parameter int PAGES         = 2,
    parameter int PATTERN_TILES = 256,
    localparam int CLR_DEPTH    = (PAGES * 1024 > PATTERN_TILES * 16) ?
                                  PAGES * 1024 : PATTERN_TILES * 16,
    localparam int CLR_W        = $clog2(CLR_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                clr_en,
    input  logic [CLR_W-1:0]    clr_addr,
    input  logic [8:0]          scroll,
    input  logic                in_accept,
    input  stmr_pkg::req_t      req,
    output stmr_pkg::stage1_t   s1
);
    import stmr_pkg::*;

    localparam int MAP_DEPTH = PAGES * 1024;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int BLK_DEPTH = PAGES * 256;
    localparam int BLK_AW    = $clog2(BLK_DEPTH);

    logic [7:0] map_mem [MAP_DEPTH];
    logic [1:0] blk_mem [BLK_DEPTH];

    logic [8:0]        wx;
    logic              world_pg;
    logic              wr_pg;
    logic              is_render;
    logic [MAP_AW-1:0] map_addr;
    logic [BLK_AW-1:0] blk_addr;
    logic              map_we;
    logic              blk_we;

    logic       v1_reg;
    req_t       req_reg;
    logic [2:0] px_reg;
    logic [2:0] py_reg;
    logic [7:0] tidx_reg;
    logic [1:0] attr_reg;

    always_comb begin
        wx        = 9'(req.screen_x) + scroll;
        world_pg  = (PAGES > 1) ? wx[8] : 1'b0;
        wr_pg     = (PAGES > 1) ? req.page : 1'b0;
        is_render = (req.req_type == REQ_RENDER);
        map_addr  = is_render ? MAP_AW'({world_pg, req.screen_y[7:3], wx[7:3]})
                              : MAP_AW'({wr_pg, req.row, req.col});
        blk_addr  = is_render ? BLK_AW'({world_pg, req.screen_y[7:4], wx[7:4]})
                              : BLK_AW'({wr_pg, req.row[3:0], req.col[3:0]});
        map_we    = in_accept && (req.req_type == REQ_TILE);
        // block positions beyond 15 are dropped
        blk_we    = in_accept && (req.req_type == REQ_ATTR) && !req.row[4] && !req.col[4];
    end

    always_ff @(posedge aclk) begin
        if (clr_en) begin
            if (int'(clr_addr) < MAP_DEPTH) begin
                map_mem[clr_addr[MAP_AW-1:0]] <= '0;
            end
        end else if (map_we) begin
            map_mem[map_addr] <= req.tile_value;
        end
        if (adv) begin
            tidx_reg <= map_mem[map_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_en) begin
            if (int'(clr_addr) < BLK_DEPTH) begin
                blk_mem[clr_addr[BLK_AW-1:0]] <= '0;
            end
        end else if (blk_we) begin
            blk_mem[blk_addr] <= req.palette_sel;
        end
        if (adv) begin
            attr_reg <= blk_mem[blk_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            req_reg <= req;
            px_reg  <= wx[2:0];
            py_reg  <= req.screen_y[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_accept;
        end
    end

    assign s1 = '{valid: v1_reg, req: req_reg, px: px_reg, py: py_reg,
                  tidx: tidx_reg, attr: attr_reg};

endmodule

FILE: rtl/core/stmr_pattern_stage.sv
// ----------------------------------------------------------------------------
// stmr_pattern_stage
// pattern byte store, second pipeline register
// ----------------------------------------------------------------------------
module stmr_pattern_stage #(
    parameter int PAGES         = 2,
    parameter int PATTERN_TILES = 256,
    localparam int CLR_DEPTH    = (PAGES * 1024 > PATTERN_TILES * 16) ?
                                  PAGES * 1024 : PATTERN_TILES * 16,
    localparam int CLR_W        = $clog2(CLR_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                clr_en,
    input  logic [CLR_W-1:0]    clr_addr,
    input  stmr_pkg::stage1_t   s1,
    output stmr_pkg::stage2_t   s2
);
    import stmr_pkg::*;

    localparam int PAT_DEPTH = PATTERN_TILES * 16;
    localparam int PAT_AW    = $clog2(PAT_DEPTH);

    logic [7:0] pat_mem [PAT_DEPTH];

    logic [PAT_AW-1:0] pat_addr;
    logic              is_render;
    logic              pat_we;

    logic       v2_reg;
    logic [2:0] kind_reg;
    logic [1:0] psel_reg;
    logic [1:0] slot_reg;
    logic [5:0] code_reg;
    logic [1:0] px_reg;
    logic [1:0] attr_reg;
    logic       in_range_reg;
    logic [7:0] pbyte_reg;

    always_comb begin
        is_render = (s1.req.req_type == REQ_RENDER);
        pat_addr  = is_render ? PAT_AW'({s1.tidx, s1.py, s1.px[2]})
                              : PAT_AW'({s1.req.pattern_tile, s1.req.pattern_byte});
        pat_we    = adv && s1.valid && (s1.req.req_type == REQ_PATTERN)
                    && (int'(s1.req.pattern_tile) < PATTERN_TILES);
    end

    always_ff @(posedge aclk) begin
        if (clr_en) begin
            if (int'(clr_addr) < PAT_DEPTH) begin
                pat_mem[clr_addr[PAT_AW-1:0]] <= '0;
            end
        end else if (pat_we) begin
            pat_mem[pat_addr] <= s1.req.tile_value;
        end
        if (adv) begin
            pbyte_reg <= pat_mem[pat_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg     <= s1.req.req_type;
            psel_reg     <= s1.req.palette_sel;
            slot_reg     <= s1.req.color_slot;
            code_reg     <= s1.req.color_code;
            px_reg       <= s1.px[1:0];
            attr_reg     <= s1.attr;
            // tile numbers past the pattern store render as backdrop
            in_range_reg <= (int'(s1.tidx) < PATTERN_TILES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= s1.valid;
        end
    end

    assign s2 = '{valid: v2_reg, kind: kind_reg, palette_sel: psel_reg,
                  color_slot: slot_reg, color_code: code_reg, px: px_reg,
                  attr: attr_reg, in_range: in_range_reg, pbyte: pbyte_reg};

endmodule

FILE: rtl/core/stmr_color_stage.sv
// ----------------------------------------------------------------------------
// stmr_color_stage
// pixel bit pick, background palettes, third pipeline register
// ----------------------------------------------------------------------------
module stmr_color_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  stmr_pkg::stage2_t   s2,
    output stmr_pkg::stage3_t   s3
);
    import stmr_pkg::*;

    logic [5:0] pal_reg [16];

    logic [1:0] pix;
    logic [3:0] pal_idx;
    logic       pal_we;

    logic       v3_reg;
    logic [5:0] shown_reg;

    always_comb begin
        unique case (s2.px)
            2'd0:    pix = s2.pbyte[7:6];
            2'd1:    pix = s2.pbyte[5:4];
            2'd2:    pix = s2.pbyte[3:2];
            default: pix = s2.pbyte[1:0];
        endcase
        if (!s2.in_range) begin
            pix = 2'd0;
        end
        // pixel value zero always shows the backdrop entry
        pal_idx = (pix == 2'd0) ? 4'd0 : {s2.attr, pix};
        pal_we  = adv && s2.valid && (s2.kind == REQ_PALETTE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                pal_reg[i] <= '0;
            end
        end else if (pal_we) begin
            pal_reg[{s2.palette_sel, s2.color_slot}] <= s2.color_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            shown_reg <= pal_reg[pal_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= s2.valid && (s2.kind == REQ_RENDER);
        end
    end

    assign s3 = '{valid: v3_reg, shown: shown_reg};

endmodule

FILE: rtl/core/scrolling_tile_map_pixel_renderer_top.sv
// ----------------------------------------------------------------------------
// scrolling_tile_map_pixel_renderer_top
// scrolling two-page background tile renderer, when not stalled one pixel per clock
// ----------------------------------------------------------------------------
// Takes one request per clock while s_ready is high and returns one RGB
// pixel per render request, stalling while the output is held; write requests
// produce nothing. The rate is set by the lookup pipeline: tile map and
// attribute stores, then the pattern store, then the palettes, each with a
// registered read port, then the output register with the master color
// table. After reset the tile map, attribute and pattern stores are zeroed
// by a clearing pass over max(PAGES*1024, PATTERN_TILES*16) entries (4096 with
// the default parameters); s_ready stays low during that pass, while scroll
// writes on cfg_we are taken at any time. Scroll must only be changed while
// no render request is in flight.
// ----------------------------------------------------------------------------
module scrolling_tile_map_pixel_renderer_top #(
    parameter int PAGES         = 2,
    parameter int PATTERN_TILES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    // scroll register
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_screen_x,
    input  logic [7:0] s_screen_y,
    input  logic       s_page,
    input  logic [4:0] s_col,
    input  logic [4:0] s_row,
    input  logic [7:0] s_tile_value,
    input  logic [7:0] s_pattern_tile,
    input  logic [3:0] s_pattern_byte,
    input  logic [1:0] s_palette_sel,
    input  logic [1:0] s_color_slot,
    input  logic [5:0] s_color_code,
    // pixel channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic [5:0] m_shown_code
);
    import stmr_pkg::*;

    localparam int CLR_DEPTH = (PAGES * 1024 > PATTERN_TILES * 16) ?
                               PAGES * 1024 : PATTERN_TILES * 16;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

    // scroll and store clearing
    logic [8:0]       scroll_reg;
    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    // pipeline
    req_t    req;
    logic    adv;
    logic    in_accept;
    stage1_t s1;
    stage2_t s2;
    stage3_t s3;

    // output register
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_red_reg;
    logic [7:0] m_green_reg;
    logic [7:0] m_blue_reg;
    logic [5:0] m_shown_reg;
    logic [23:0] rgb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scroll_reg <= '0;
        end else if (cfg_we) begin
            scroll_reg <= cfg_wdata;
        end
    end

    // one store entry per clock after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            if (clr_cnt_reg == CLR_LAST) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // the whole pipeline moves unless a finished pixel sits in the last
    // stage and the output register is still held by the sink
    assign adv       = !(s3.valid && m_valid_reg && !m_ready);
    assign s_ready   = adv && !clr_busy_reg;
    assign in_accept = s_valid && s_ready;

    assign req = '{req_type: s_req_type, screen_x: s_screen_x, screen_y: s_screen_y,
                   page: s_page, col: s_col, row: s_row, tile_value: s_tile_value,
                   pattern_tile: s_pattern_tile, pattern_byte: s_pattern_byte,
                   palette_sel: s_palette_sel, color_slot: s_color_slot,
                   color_code: s_color_code};

    // tile index and block palette lookup
    stmr_map_stage #(
        .PAGES         (PAGES),
        .PATTERN_TILES (PATTERN_TILES)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .clr_en    (clr_busy_reg),
        .clr_addr  (clr_cnt_reg),
        .scroll    (scroll_reg),
        .in_accept (in_accept),
        .req       (req),
        .s1        (s1)
    );

    // pattern bits lookup
    stmr_pattern_stage #(
        .PAGES         (PAGES),
        .PATTERN_TILES (PATTERN_TILES)
    ) u_pattern (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .clr_en   (clr_busy_reg),
        .clr_addr (clr_cnt_reg),
        .s1       (s1),
        .s2       (s2)
    );

    // palette color code lookup
    stmr_color_stage u_color (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .s2      (s2),
        .s3      (s3)
    );

    // master color table in front of the output register
    assign rgb = rgb_lookup(s3.shown);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = s3.valid || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s3.valid) begin
            m_red_reg   <= rgb[23:16];
            m_green_reg <= rgb[15:8];
            m_blue_reg  <= rgb[7:0];
            m_shown_reg <= s3.shown;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = m_red_reg;
    assign m_green      = m_green_reg;
    assign m_blue       = m_blue_reg;
    assign m_shown_code = m_shown_reg;

    // no request taken while the stores are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready)
        else $error("request accepted during store clearing");

    // clearing ends only after the last entry
    a_clear_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> ($past(clr_cnt_reg) == CLR_LAST))
        else $error("store clearing ended early");

    // color components agree with the shown code
    a_rgb_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({m_red_reg, m_green_reg, m_blue_reg} == rgb_lookup(m_shown_reg)))
        else $error("pixel color does not match shown code");

    // a stall leaves the last stage unchanged unless the sink is ready
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(s3) || m_ready)
        else $error("pipeline moved during stall");

endmodule
